### sv/bhpq_pkg.sv
// Shared types, constants and the order compare for the binary heap priority queue.
// No dependencies; imported by bhpq_cell, binary_heap_priority_queue_top and the testbench.
package bhpq_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int DATA_W           = 32;
   localparam int STATUS_W         = 2;
   localparam int FILL_W           = 7;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic ORDER_MIN = 1'b0;
   localparam logic ORDER_MAX = 1'b1;

   typedef struct packed {
      logic do_insert;
      logic do_remove;
      logic sorting;
      logic phase_odd;
      logic order;
   } cell_ctrl_type;

   // true when a belongs nearer the root than b
   function automatic logic beats(input logic order,
                                  input logic signed [DATA_W-1:0] a,
                                  input logic signed [DATA_W-1:0] b);
      logic result;
      if (order == ORDER_MAX) begin
         result = a > b;
      end else begin
         result = a < b;
      end
      return result;
   endfunction

endpackage

### sv/bhpq_cell.sv
// One slot of the sorted cell row: holds a value and a valid bit, trades with neighbors.
// Depends on bhpq_pkg for the control struct and the order compare.
module bhpq_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  bhpq_pkg::cell_ctrl_type             ctrl,
   input  logic signed [bhpq_pkg::DATA_W-1:0]  ins_value,
   input  logic                                is_head,
   input  logic                                pos_odd,
   input  logic signed [bhpq_pkg::DATA_W-1:0]  left_value,
   input  logic                                left_valid,
   input  logic                                left_goes,
   input  logic signed [bhpq_pkg::DATA_W-1:0]  right_value,
   input  logic                                right_valid,
   input  logic                                right_swap,
   output logic signed [bhpq_pkg::DATA_W-1:0]  value,
   output logic                                valid,
   output logic                                goes,
   output logic                                swap_up
);
   import bhpq_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     valid_ff;
   logic                     valid_in;

   always_comb begin
      goes    = !valid_ff || beats(ctrl.order, ins_value, value_ff);
      swap_up = !is_head && valid_ff && left_valid && beats(ctrl.order, value_ff, left_value);
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.sorting) begin
         if (pos_odd == ctrl.phase_odd) begin
            if (right_swap) begin
               value_in = right_value;
            end
         end else if (swap_up) begin
            value_in = left_value;
         end
      end else if (ctrl.do_insert) begin
         valid_in = valid_ff || is_head || left_valid;
         if (left_goes) begin
            value_in = left_value;
         end else if (goes) begin
            value_in = ins_value;
         end
      end else if (ctrl.do_remove) begin
         value_in = right_value;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

### sv/binary_heap_priority_queue_top.sv
// Top level of the binary heap priority queue: a row of CAPACITY sorted cells and control.
// Depends on bhpq_pkg and bhpq_cell.
//
// Usage: the req channel carries one transaction per command (insert data_in or remove
// the root); the rsp channel returns exactly one transaction per command with the removed
// value, a status code and the entry count after the command. Both use valid and stall.
// The cells keep the entries sorted with the root in the first cell, so every command
// completes in the cycle it is taken: the result is registered into rsp, or into the skid
// register while rsp is stalled; one command can be taken per cycle while req_stall is low.
// The csr channel writes the order (0 min, 1 max). A write that changes the order starts
// an odd-even exchange pass across the row; req_stall and csr_ready hold off new
// transactions until it finishes.
// A result stalled on rsp is held; one more command is taken into a skid register, then
// req_stall rises until rsp drains.
// Reset is synchronous: the queue empties, the order returns to min, and rsp goes idle.
module binary_heap_priority_queue_top #(
   parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic signed [bhpq_pkg::DATA_W-1:0]   req_data_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bhpq_pkg::DATA_W-1:0]   rsp_data_out,
   output logic [bhpq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bhpq_pkg::FILL_W-1:0]          rsp_fill_count,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_heap_order
);
   import bhpq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic [FILL_W-1:0]        fill;
   } result_type;

   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic                     cell_valid [CAPACITY];
   logic                     cell_goes  [CAPACITY];
   logic                     cell_swap  [CAPACITY];

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         sort_cnt_ff;
   logic [CNT_W-1:0]         sort_cnt_in;
   logic                     order_ff;
   logic                     order_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   result_type               rsp_ff;
   result_type               rsp_in;
   logic                     skid_valid_ff;
   logic                     skid_valid_in;
   result_type               skid_ff;
   result_type               skid_in;

   logic                     sorting;
   logic                     accept;
   logic                     cfg_write;
   logic                     full;
   logic                     empty;
   logic                     do_insert;
   logic                     do_remove;
   logic                     out_free;
   logic [CNT_W+FILL_W-1:0]  fill_wide;
   result_type               result;
   cell_ctrl_type            ctrl;

   assign sorting   = sort_cnt_ff != '0;
   assign req_stall = sorting || skid_valid_ff;
   assign csr_ready = !sorting;
   assign accept    = req_valid && !req_stall;
   assign cfg_write = csr_valid && csr_ready;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign empty     = count_ff == '0;
   assign do_insert = accept && (req_command == CMD_INSERT) && !full;
   assign do_remove = accept && (req_command == CMD_REMOVE) && !empty;

   always_comb begin
      ctrl.do_insert = do_insert;
      ctrl.do_remove = do_remove;
      ctrl.sorting   = sorting;
      ctrl.phase_odd = sort_cnt_ff[0];
      ctrl.order     = order_ff;
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [DATA_W-1:0] left_value;
         logic                     left_valid;
         logic                     left_goes;
         logic signed [DATA_W-1:0] right_value;
         logic                     right_valid;
         logic                     right_swap;

         if (i == 0) begin : g_head
            assign left_value = '0;
            assign left_valid = 1'b0;
            assign left_goes  = 1'b0;
         end else begin : g_body
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_goes  = cell_goes[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
            assign right_swap  = 1'b0;
         end else begin : g_mid
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
            assign right_swap  = cell_swap[i+1];
         end

         bhpq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .ins_value   (req_data_in),
            .is_head     (i == 0),
            .pos_odd     (1'(i % 2)),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .left_goes   (left_goes),
            .right_value (right_value),
            .right_valid (right_valid),
            .right_swap  (right_swap),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .goes        (cell_goes[i]),
            .swap_up     (cell_swap[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end

      fill_wide = {{FILL_W{1'b0}}, count_in};

      result.data   = '0;
      result.status = STATUS_OK;
      result.fill   = fill_wide[FILL_W-1:0];
      if (req_command == CMD_REMOVE) begin
         if (empty) begin
            result.status = STATUS_EMPTY;
         end else begin
            result.data = cell_value[0];
         end
      end else if (full) begin
         result.status = STATUS_FULL;
      end

      order_in    = order_ff;
      sort_cnt_in = sort_cnt_ff;
      if (sorting) begin
         sort_cnt_in = sort_cnt_ff - CNT_W'(1);
      end
      if (cfg_write && (csr_heap_order != order_ff)) begin
         order_in    = csr_heap_order;
         sort_cnt_in = CNT_W'(CAPACITY);
      end

      out_free      = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            rsp_valid_in = 1'b1;
            rsp_in       = result;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
      if (reset) begin
         count_ff      <= '0;
         sort_cnt_ff   <= '0;
         order_ff      <= ORDER_MIN;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sort_cnt_ff   <= sort_cnt_in;
         order_ff      <= order_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_ff.data;
   assign rsp_status     = rsp_ff.status;
   assign rsp_fill_count = rsp_ff.fill;

endmodule

### sim/testbench.sv
// Self-checking testbench for binary_heap_priority_queue_top: min/max heap commands,
// order rewrites, empty and full cases, random traffic with sender and receiver idling.
// Depends on bhpq_pkg and binary_heap_priority_queue_top.
module testbench;
   import bhpq_pkg::*;

   localparam int HEAP_SIZE     = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      logic signed [DATA_W-1:0] data_out;
      status_type               status;
      logic [FILL_W-1:0]        fill_count;
   } heap_result_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic                     req_command    = CMD_INSERT;
   logic signed [DATA_W-1:0] req_data_in    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic [STATUS_W-1:0]      rsp_status;
   logic [FILL_W-1:0]        rsp_fill_count;
   logic                     csr_valid      = 1'b0;
   logic                     csr_ready;
   logic                     csr_heap_order = ORDER_MIN;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int cycle_count        = 0;

   logic signed [DATA_W-1:0] heap_model [HEAP_SIZE];
   int                       held_count = 0;
   logic                     order_now  = ORDER_MIN;
   heap_result_type          pending_results [$];

   binary_heap_priority_queue_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_heap_order (csr_heap_order)
   );

   always #2 clock = ~clock;

   function automatic logic outranks(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
      return (order_now == ORDER_MAX) ? (a > b) : (a < b);
   endfunction

   function automatic void swap_entries(input int i, input int j);
      logic signed [DATA_W-1:0] t;
      t = heap_model[i];
      heap_model[i] = heap_model[j];
      heap_model[j] = t;
   endfunction

   function automatic void sift_down_from(input int start);
      int   pos;
      int   left;
      int   right;
      int   best;
      logic done;
      pos  = start;
      done = 1'b0;
      while (!done) begin
         left  = 2 * pos + 1;
         right = 2 * pos + 2;
         best  = pos;
         if (left < held_count && outranks(heap_model[left], heap_model[best])) begin
            best = left;
         end
         if (right < held_count && outranks(heap_model[right], heap_model[best])) begin
            best = right;
         end
         if (best == pos) begin
            done = 1'b1;
         end else begin
            swap_entries(best, pos);
            pos = best;
         end
      end
   endfunction

   function automatic void sift_up_from(input int start);
      int   pos;
      int   parent;
      logic done;
      pos  = start;
      done = 1'b0;
      while (pos > 0 && !done) begin
         parent = (pos - 1) / 2;
         if (outranks(heap_model[pos], heap_model[parent])) begin
            swap_entries(pos, parent);
            pos = parent;
         end else begin
            done = 1'b1;
         end
      end
   endfunction

   function automatic void reorder_heap();
      for (int i = held_count / 2 - 1; i >= 0; i--) begin
         sift_down_from(i);
      end
   endfunction

   function automatic heap_result_type predict_command(input logic cmd,
                                                       input logic signed [DATA_W-1:0] value);
      heap_result_type r;
      r.data_out = '0;
      r.status   = STATUS_OK;
      if (cmd == CMD_INSERT) begin
         if (held_count >= HEAP_SIZE) begin
            r.status = STATUS_FULL;
         end else begin
            heap_model[held_count] = value;
            held_count++;
            sift_up_from(held_count - 1);
         end
      end else if (held_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.data_out = heap_model[0];
         held_count--;
         heap_model[0] = heap_model[held_count];
         sift_down_from(0);
      end
      r.fill_count = held_count[FILL_W-1:0];
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(3))
         0: v = int'($urandom_range(8)) - 4;
         1: begin
            case ($urandom_range(3))
               0: v = 32'sh7FFFFFFF;
               1: v = 32'sh80000000;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_command(input logic cmd, input logic signed [DATA_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_data_in <= value;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_command(cmd, value));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_heap_order(input logic order);
      drain_results();
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_heap_order <= order;
      do @(posedge clock); while (!csr_ready);
      if (order != order_now) begin
         order_now = order;
         reorder_heap();
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idle_phase(input int sender_pct, input int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   task automatic test_empty_and_extremes();
      send_command(CMD_REMOVE, 123);
      send_command(CMD_INSERT, 32'sh7FFFFFFF);
      send_command(CMD_INSERT, 32'sh80000000);
      send_command(CMD_INSERT, 0);
      send_command(CMD_INSERT, -1);
      send_command(CMD_INSERT, 1);
      send_command(CMD_INSERT, 5);
      send_command(CMD_INSERT, 5);
      repeat (7) send_command(CMD_REMOVE, $urandom);
      send_command(CMD_REMOVE, -1);
   endtask

   task automatic test_order_switch();
      send_command(CMD_INSERT, 3);
      send_command(CMD_INSERT, -9);
      send_command(CMD_INSERT, 12);
      send_command(CMD_INSERT, 12);
      write_heap_order(ORDER_MAX);
      send_command(CMD_REMOVE, 0);
      write_heap_order(ORDER_MAX);
      send_command(CMD_REMOVE, 0);
      write_heap_order(ORDER_MIN);
      send_command(CMD_REMOVE, 0);
      send_command(CMD_REMOVE, 0);
   endtask

   task automatic test_fill_and_overflow();
      repeat (HEAP_SIZE + 3) send_command(CMD_INSERT, pick_value());
      write_heap_order(~order_now);
      repeat (HEAP_SIZE + 2) send_command(CMD_REMOVE, $urandom);
   endtask

   task automatic test_random_mix(input int count);
      int insert_pct;
      insert_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            case ($urandom_range(2))
               0: insert_pct = 15;
               1: insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         if (i == count / 2) begin
            drain_results();
         end
         send_command(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                      pick_value());
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_error($sformatf("result with none pending, data_out %0d", rsp_data_out));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data_out !== want.data_out) begin
               report_error($sformatf("data_out got %0d want %0d",
                                      rsp_data_out, want.data_out));
            end
            if (rsp_status !== want.status) begin
               report_error($sformatf("status got %0d want %0d", rsp_status, want.status));
            end
            if (rsp_fill_count !== want.fill_count) begin
               report_error($sformatf("fill_count got %0d want %0d",
                                      rsp_fill_count, want.fill_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** binary_heap_priority_queue_top: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_order_switch();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: set_idle_phase(0, 0);
            1: set_idle_phase(82, 0);
            2: set_idle_phase(0, 82);
            default: set_idle_phase(23, 23);
         endcase
         test_fill_and_overflow();
         test_random_mix(120);
         write_heap_order(logic'($urandom_range(1)));
         test_random_mix(130);
      end
      drain_results();
      if (error_count == 0) begin
         $display("** binary_heap_priority_queue_top: PASSED **");
      end else begin
         $display("** binary_heap_priority_queue_top: FAILED **");
      end
      $finish;
   end

endmodule
